// ----- design/grs_pkg.sv -----
// Package: types, constants and round functions for the Groestl-512 engine.
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int NUM_ROUNDS  = 14;
   localparam int COLS        = 16;
   localparam int ROWS        = 8;

   localparam logic [6:0] DIGEST_MIN   = 7'd33;
   localparam logic [6:0] DIGEST_MAX   = 7'd64;
   localparam logic [6:0] LAST_POS     = 7'(BLOCK_BYTES - 1);
   localparam logic [6:0] COUNT_POS    = 7'(BLOCK_BYTES - 8);
   localparam logic [3:0] LAST_ROUND   = 4'(NUM_ROUNDS - 1);
   localparam logic [7:0] PAD_MARK     = 8'h80;

   // state byte k sits at column k/8, row k%8; byte 0 is the MSB byte
   typedef logic [0:BLOCK_BYTES-1][7:0] state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_CLOAD,
      ST_CRUN,
      ST_FLOAD,
      ST_FRUN,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic absorb;
      logic pad_start;
      logic pad_shift;
      logic comp_load;
      logic comp_round;
      logic fin_load;
      logic fin_round;
      logic out_step;
      logic restart;
   } grs_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic round_last;
      logic padding;
      logic cnt_ok;
      logic out_last;
   } grs_stat_type;

   localparam int SHIFT_P [ROWS] = '{0, 1, 2, 3, 4, 5, 6, 11};
   localparam int SHIFT_Q [ROWS] = '{1, 3, 5, 11, 0, 2, 4, 6};
   localparam logic [2:0] MIX_COEF [ROWS] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd5, 3'd7};

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] gf_dbl(logic [7:0] x);
      gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(logic [7:0] x, logic [2:0] c);
      logic [7:0] x2;
      logic [7:0] x4;
      logic [7:0] r;
      x2 = gf_dbl(x);
      x4 = gf_dbl(x2);
      r  = 8'h00;
      if (c[0]) r = r ^ x;
      if (c[1]) r = r ^ x2;
      if (c[2]) r = r ^ x4;
      gf_mul = r;
   endfunction

   // one round of P (is_q = 0) or Q (is_q = 1)
   function automatic state_type grs_round(state_type s, logic [3:0] rnd, logic is_q);
      state_type a;
      state_type t;
      state_type o;
      logic [7:0] acc;
      int sh;
      for (int c = 0; c < COLS; c++) begin
         for (int i = 0; i < ROWS; i++) begin
            a[c*ROWS+i] = s[c*ROWS+i] ^ (is_q ? 8'hff : 8'h00);
            if ((!is_q && i == 0) || (is_q && i == ROWS - 1))
               a[c*ROWS+i] = a[c*ROWS+i] ^ {4'(c), rnd};
         end
      end
      for (int c = 0; c < COLS; c++) begin
         for (int i = 0; i < ROWS; i++) begin
            sh = is_q ? SHIFT_Q[i] : SHIFT_P[i];
            t[c*ROWS+i] = SBOX[a[((c + sh) % COLS)*ROWS+i]];
         end
      end
      for (int c = 0; c < COLS; c++) begin
         for (int i = 0; i < ROWS; i++) begin
            acc = 8'h00;
            for (int k = 0; k < ROWS; k++)
               acc = acc ^ gf_mul(t[c*ROWS+k], MIX_COEF[(k - i + ROWS) % ROWS]);
            o[c*ROWS+i] = acc;
         end
      end
      grs_round = o;
   endfunction

   function automatic state_type iv_of(logic [6:0] n);
      state_type v;
      v = '0;
      v[BLOCK_BYTES-2] = {6'b0, n[6:5]};
      v[BLOCK_BYTES-1] = {n[4:0], 3'b0};
      iv_of = v;
   endfunction

endpackage

`default_nettype wire

// ----- design/grs_if.sv -----
// Interfaces: message word channel and digest word channel.
`timescale 1ns / 1ps
`default_nettype none

interface grs_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;
   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface grs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] digest_byte;
   logic       last;
   modport source (output valid, digest_byte, last, input ready);
   modport sink   (input valid, digest_byte, last, output ready);
endinterface

`default_nettype wire

// ----- design/grs_ctrl.sv -----
// Controller: sequences absorb, padding, compression, output transform and readout.
`timescale 1ns / 1ps
`default_nettype none

module grs_ctrl
   import grs_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_we,
   input  wire logic   req_valid,
   input  wire logic   req_action,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   input  wire grs_stat_type stat,
   output grs_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_action) begin
                  cmd.absorb = 1'b1;
                  if (stat.fill_last) state_in = ST_CLOAD;
               end else begin
                  cmd.pad_start = 1'b1;
                  state_in      = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.pad_shift = 1'b1;
            if (stat.fill_last) state_in = ST_CLOAD;
         end
         ST_CLOAD: begin
            cmd.comp_load = 1'b1;
            state_in      = ST_CRUN;
         end
         ST_CRUN: begin
            cmd.comp_round = 1'b1;
            if (stat.round_last) begin
               if (!stat.padding)    state_in = ST_IDLE;
               else if (stat.cnt_ok) state_in = ST_FLOAD;
               else                  state_in = ST_PAD;
            end
         end
         ST_FLOAD: begin
            cmd.fin_load = 1'b1;
            state_in     = ST_FRUN;
         end
         ST_FRUN: begin
            cmd.fin_round = 1'b1;
            if (stat.round_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.out_last) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.out_step = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/grs_dp.sv -----
// Datapath: message shift register, chaining value, P/Q round unit and counters.
`timescale 1ns / 1ps
`default_nettype none

module grs_dp
   import grs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata,
   input  wire logic [7:0]  data_byte,
   input  wire grs_cmd_type cmd,
   output grs_stat_type     stat,
   output logic [7:0]       digest_byte,
   output logic             last
);

   state_type   h_ff, m_ff, p_ff, q_ff;
   state_type   p_next, q_next;
   logic [6:0]  digest_ff, digest_in;
   logic [6:0]  fill_ff;
   logic [63:0] blocks_ff;
   logic [63:0] total_ff;
   logic        padding_ff, cnt_ok_ff, first_ff;
   logic [3:0]  rnd_ff;
   logic [6:0]  out_idx_ff;
   logic [7:0]  pad_byte;
   logic        count_byte;

   assign p_next = grs_round(p_ff, rnd_ff, 1'b0);
   assign q_next = grs_round(q_ff, rnd_ff, 1'b1);

   assign count_byte = cnt_ok_ff && !first_ff && (fill_ff >= COUNT_POS);

   always_comb begin
      if (first_ff)        pad_byte = PAD_MARK;
      else if (count_byte) pad_byte = total_ff[63:56];
      else                 pad_byte = 8'h00;
   end

   always_comb begin
      if (csr_wdata < DIGEST_MIN)      digest_in = DIGEST_MIN;
      else if (csr_wdata > DIGEST_MAX) digest_in = DIGEST_MAX;
      else                             digest_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digest_ff  <= DIGEST_MAX;
         h_ff       <= iv_of(DIGEST_MAX);
         fill_ff    <= '0;
         blocks_ff  <= '0;
         padding_ff <= 1'b0;
         cnt_ok_ff  <= 1'b0;
         first_ff   <= 1'b0;
         rnd_ff     <= '0;
         out_idx_ff <= '0;
      end else if (csr_we) begin
         digest_ff  <= digest_in;
         h_ff       <= iv_of(digest_in);
         fill_ff    <= '0;
         blocks_ff  <= '0;
         padding_ff <= 1'b0;
      end else begin
         if (cmd.absorb) begin
            m_ff    <= {m_ff[1:BLOCK_BYTES-1], data_byte};
            fill_ff <= fill_ff + 7'd1;
         end
         if (cmd.pad_start) begin
            total_ff   <= blocks_ff + ((fill_ff < COUNT_POS) ? 64'd1 : 64'd2);
            cnt_ok_ff  <= fill_ff < COUNT_POS;
            first_ff   <= 1'b1;
            padding_ff <= 1'b1;
         end
         if (cmd.pad_shift) begin
            m_ff     <= {m_ff[1:BLOCK_BYTES-1], pad_byte};
            fill_ff  <= fill_ff + 7'd1;
            first_ff <= 1'b0;
            if (count_byte) total_ff <= {total_ff[55:0], 8'h00};
         end
         if (cmd.comp_load) begin
            p_ff   <= h_ff ^ m_ff;
            q_ff   <= m_ff;
            rnd_ff <= '0;
         end
         if (cmd.comp_round) begin
            p_ff   <= p_next;
            q_ff   <= q_next;
            rnd_ff <= rnd_ff + 4'd1;
            if (rnd_ff == LAST_ROUND) begin
               h_ff      <= h_ff ^ p_next ^ q_next;
               blocks_ff <= blocks_ff + 64'd1;
               if (padding_ff) cnt_ok_ff <= 1'b1;
            end
         end
         if (cmd.fin_load) begin
            p_ff   <= h_ff;
            rnd_ff <= '0;
         end
         if (cmd.fin_round) begin
            p_ff   <= p_next;
            rnd_ff <= rnd_ff + 4'd1;
            if (rnd_ff == LAST_ROUND) begin
               h_ff       <= h_ff ^ p_next;
               out_idx_ff <= 7'(8'(BLOCK_BYTES) - {1'b0, digest_ff});
            end
         end
         if (cmd.out_step) out_idx_ff <= out_idx_ff + 7'd1;
         if (cmd.restart) begin
            h_ff       <= iv_of(digest_ff);
            fill_ff    <= '0;
            blocks_ff  <= '0;
            padding_ff <= 1'b0;
         end
      end
   end

   assign stat.fill_last  = fill_ff == LAST_POS;
   assign stat.round_last = rnd_ff == LAST_ROUND;
   assign stat.padding    = padding_ff;
   assign stat.cnt_ok     = cnt_ok_ff;
   assign stat.out_last   = out_idx_ff == LAST_POS;

   assign digest_byte = h_ff[out_idx_ff];
   assign last        = out_idx_ff == LAST_POS;

endmodule

`default_nettype wire

// ----- design/groestl512_hash_engine.sv -----
// Top level: Groestl-512 hash engine over a byte stream.
//
// Message words are taken one per cycle. After every 128th byte the block is
// compressed by a round unit that runs one P round and one Q round per cycle,
// so the input stalls while the block is loaded and the rounds run. An end
// word pads the message at one byte per cycle up to the block boundary (one or
// two blocks), compresses them, runs the output transform and then delivers
// digest_bytes words, one per cycle while the sink is ready, with last on the
// final one. Writing csr_wdata sets the digest length (clamped to 33..64) and
// starts a new message.
`timescale 1ns / 1ps
`default_nettype none

module groestl512_hash_engine
   import grs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   grs_req_if.sink          req_ch,
   grs_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata
);

   grs_cmd_type  cmd;
   grs_stat_type stat;

   grs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   grs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .data_byte   (req_ch.data_byte),
      .cmd         (cmd),
      .stat        (stat),
      .digest_byte (rsp_ch.digest_byte),
      .last        (rsp_ch.last)
   );

endmodule

`default_nettype wire
